[rtl/core/hhs_pkg.sv]
package hhs_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 64;
    localparam int DIGITS = 6;
    localparam int SECS_W = 17;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_LEN   = 3'd1,
        ST_DIGIT = 3'd2,
        ST_HOUR  = 3'd3,
        ST_MIN   = 3'd4,
        ST_SEC   = 3'd5
    } t_status;

    // Snapshot of a finished line, handed from the assembler to the checker.
    typedef struct packed {
        logic                 len_err;
        logic                 bad_digit;
        logic [DIGITS-1:0][3:0] digits;
    } t_line_info;

endpackage

[rtl/core/hhs_line_asm.sv]
module hhs_line_asm import hhs_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_line_info o_info
);

    localparam int CNT_W = $clog2(LINE_BUFFER_BYTES);
    localparam int IDX_W = $clog2(DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_DIGITS = CNT_W'(DIGITS);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_bad, n_bad;
    logic [3:0]       r_digits [DIGITS];

    logic is_end, is_digit, empty, full, store;

    assign is_end   = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign empty    = (r_count == '0);
    assign full     = (r_count == CNT_LAST);
    assign store    = i_step && !is_end && !full && (r_count < CNT_DIGITS);

    assign o_emit = i_step && (is_end ? !empty : full);

    // A too-long line reports a length error regardless of its contents.
    always_comb begin
        o_info.len_err   = !is_end || (r_count != CNT_DIGITS);
        o_info.bad_digit = r_bad;
        for (int i = 0; i < DIGITS; i++) begin
            o_info.digits[i] = r_digits[i];
        end
    end

    always_comb begin
        n_count = r_count;
        n_bad   = r_bad;
        if (i_step) begin
            if (is_end) begin
                if (!empty) begin
                    n_count = '0;
                    n_bad   = 1'b0;
                end
            end else if (full) begin
                n_count = '0;
                n_bad   = 1'b0;
            end else begin
                n_count = r_count + 1'b1;
                if ((r_count < CNT_DIGITS) && !is_digit) begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_digits[r_count[IDX_W-1:0]] <= is_digit ? 4'(i_byte - CH_ZERO) : 4'd0;
        end
    end

endmodule

[rtl/core/hhs_line_check.sv]
module hhs_line_check import hhs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  t_line_info        i_info,
    output t_status           o_status,
    output logic [SECS_W-1:0] o_secs
);

    t_status           r_status, n_status;
    logic [SECS_W-1:0] r_secs, n_secs;
    logic [6:0]        hours, minutes, secs;

    assign hours   = 7'(i_info.digits[0]) * 7'd10 + 7'(i_info.digits[1]);
    assign minutes = 7'(i_info.digits[2]) * 7'd10 + 7'(i_info.digits[3]);
    assign secs    = 7'(i_info.digits[4]) * 7'd10 + 7'(i_info.digits[5]);

    always_comb begin
        n_secs = '0;
        if (i_info.len_err) begin
            n_status = ST_LEN;
        end else if (i_info.bad_digit) begin
            n_status = ST_DIGIT;
        end else if (hours > 7'd23) begin
            n_status = ST_HOUR;
        end else if (minutes > 7'd59) begin
            n_status = ST_MIN;
        end else if (secs > 7'd59) begin
            n_status = ST_SEC;
        end else begin
            n_status = ST_OK;
            n_secs   = SECS_W'(hours) * SECS_W'(3600) + SECS_W'(minutes) * SECS_W'(60)
                       + SECS_W'(secs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_secs   <= n_secs;
        end
    end

    assign o_status = r_status;
    assign o_secs   = r_secs;

endmodule

[rtl/core/hhmmss_line_to_seconds.sv]
// Assembles received characters into lines and converts an "HHMMSS" line
// into seconds since midnight.
// Input channel: i_valid / o_stall with one character in i_rx_byte per item.
// CR or LF ends a non-empty line and produces one result; other characters
// produce none, except a character that would overflow the line buffer,
// which is dropped, clears the line and yields a length error.
// Output channel: o_valid / i_stall with o_status and o_seconds_of_day.
// An item lands in an input register and is processed against the line
// state once the output register is free; its result is captured in the
// output register, which drives o_valid.
// Throughput is one item per cycle while the receiver does not stall, set by the single processing stage.
// While the receiver stalls, the result holds and one more item can sit in
// the input register; o_stall rises only when both registers are occupied.
// Reset (synchronous, active low) empties the line and both registers.
module hhmmss_line_to_seconds import hhs_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic [SECS_W-1:0] o_seconds_of_day
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_rx_byte;
    logic       r_out_valid, n_out_valid;
    logic       out_free, step, load, emit;
    t_line_info info;
    t_status    status;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign load     = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (load) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = out_free ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rx_byte <= i_rx_byte;
        end
    end

    hhs_line_asm #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_asm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (r_rx_byte),
        .o_emit (emit),
        .o_info (info)
    );

    hhs_line_check u_check (
        .i_clk   (i_clk),
        .i_load  (emit),
        .i_info  (info),
        .o_status(status),
        .o_secs  (o_seconds_of_day)
    );

    assign o_valid  = r_out_valid;
    assign o_status = status;

endmodule

[dv/hhmmss_line_to_seconds_test.sv]
module hhmmss_line_to_seconds_test;
    import hhs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LINE_MAX     = LINE_BUFFER_BYTES_DEF - 1;
    localparam int         TOTAL_ITEMS  = 1950;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [7:0] FILL_CHAR    = "7";

    typedef struct packed {
        t_status           status;
        logic [SECS_W-1:0] secs;
    } t_time_result;

    typedef struct {
        string      text;
        int         nul_at;     // index of text sent as a zero byte, -1 for none
        int         fill;       // filler characters appended after text
        logic [7:0] term;
        bit         typed;      // result below is taken as written
        t_status    status;
        int         secs;
    } t_line_case;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_rx_byte = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_status;
    logic [SECS_W-1:0] o_seconds_of_day;

    hhmmss_line_to_seconds u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_seconds_of_day (o_seconds_of_day)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line state mirrored from the block.
    logic [5:0]   line_len = '0;
    logic [3:0]   held_digit [DIGITS];
    logic         saw_non_digit = 1'b0;

    t_time_result pending_results [$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           status_seen [6];
    int           burst_left = 0;
    bit           hold_req = 1'b0;

    t_line_case line_cases [] = '{
        '{"",        -1,  0, CH_LF, 1'b0, ST_OK,    0},
        '{"000000",  -1,  0, CH_CR, 1'b1, ST_OK,    0},
        '{"235959",  -1,  0, CH_LF, 1'b1, ST_OK,    86399},
        '{"12345",   -1,  0, CH_LF, 1'b1, ST_LEN,   0},
        '{"1234567", -1,  0, CH_CR, 1'b1, ST_LEN,   0},
        '{"/:0909",  -1,  0, CH_LF, 1'b1, ST_DIGIT, 0},
        '{"120000",   3,  0, CH_CR, 1'b1, ST_DIGIT, 0},
        '{"240000",  -1,  0, CH_LF, 1'b1, ST_HOUR,  0},
        '{"126000",  -1,  0, CH_CR, 1'b1, ST_MIN,   0},
        '{"120060",  -1,  0, CH_LF, 1'b1, ST_SEC,   0},
        '{"073015",  -1,  0, CH_CR, 1'b0, ST_OK,    0},
        '{"",        -1, 64, CH_LF, 1'b1, ST_LEN,   0}
    };

    // Applies one character to the mirrored line; returns 1 when it yields a result.
    function automatic bit predict_line_char(input logic [7:0] ch, output t_time_result res);
        int hh, mm, ss;
        res = '{status: ST_OK, secs: '0};
        if (ch == CH_CR || ch == CH_LF) begin
            if (line_len == 0) return 1'b0;
            hh = held_digit[0] * 10 + held_digit[1];
            mm = held_digit[2] * 10 + held_digit[3];
            ss = held_digit[4] * 10 + held_digit[5];
            if (line_len != DIGITS)  res.status = ST_LEN;
            else if (saw_non_digit)  res.status = ST_DIGIT;
            else if (hh > 23)        res.status = ST_HOUR;
            else if (mm > 59)        res.status = ST_MIN;
            else if (ss > 59)        res.status = ST_SEC;
            else                     res.secs = SECS_W'(hh * 3600 + mm * 60 + ss);
            line_len = '0;
            saw_non_digit = 1'b0;
            return 1'b1;
        end
        if (line_len >= LINE_MAX) begin
            // Overflowing character is dropped and the line starts over.
            res.status = ST_LEN;
            line_len = '0;
            saw_non_digit = 1'b0;
            return 1'b1;
        end
        if (line_len < DIGITS) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                held_digit[line_len] = 4'(ch - CH_ZERO);
            end else begin
                held_digit[line_len] = '0;
                saw_non_digit = 1'b1;
            end
        end
        line_len++;
        return 1'b0;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic send_item(input logic [7:0] b, input bit typed, input t_time_result typed_res);
        int           gap;
        t_time_result res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        if (!((b == CH_CR || b == CH_LF) && line_len == 0)) items_sent++;
        if (predict_line_char(b, res)) begin
            if (typed) res = typed_res;
            status_seen[res.status]++;
            pending_results.push_back(res);
        end
    endtask

    task automatic send_chars(input logic [7:0] q [$], input bit typed,
                              input t_time_result typed_res);
        foreach (q[i]) send_item(q[i], typed, typed_res);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request.
    initial begin
        int mode, mode_left, hold_left, cyc;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= (hold_left != 0);
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((cyc % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_time_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d seconds %0d",
                             o_status, o_seconds_of_day);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_seconds_of_day !== want.secs) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d seconds %0d, got status %0d seconds %0d",
                                 want.status, want.secs, o_status, o_seconds_of_day);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL hhmmss_line_to_seconds");
        $finish;
    end

    initial begin
        logic [7:0]   chars [$];
        t_time_result typed_res;
        int           kind, hh, mm, ss, n;
        foreach (held_digit[i]) held_digit[i] = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_cases[r]) begin
            chars.delete();
            for (int k = 0; k < line_cases[r].text.len(); k++)
                chars.push_back((k == line_cases[r].nul_at) ? NUL_CHAR : line_cases[r].text[k]);
            repeat (line_cases[r].fill) chars.push_back(FILL_CHAR);
            chars.push_back(line_cases[r].term);
            typed_res.status = line_cases[r].status;
            typed_res.secs   = SECS_W'(line_cases[r].secs);
            send_chars(chars, line_cases[r].typed, typed_res);
        end

        hold_req = 1'b1;
        typed_res = '0;
        while (items_sent < TOTAL_ITEMS) begin
            chars.delete();
            kind = $urandom_range(0, 99);
            if (kind < 55 || kind >= 70) begin
                hh = $urandom_range(0, 23);
                mm = $urandom_range(0, 59);
                ss = $urandom_range(0, 59);
            end else begin
                hh = $urandom_range(0, 29);
                mm = $urandom_range(0, 69);
                ss = $urandom_range(0, 69);
            end
            if (kind < 78) begin
                chars = '{CH_ZERO + 8'(hh / 10), CH_ZERO + 8'(hh % 10),
                          CH_ZERO + 8'(mm / 10), CH_ZERO + 8'(mm % 10),
                          CH_ZERO + 8'(ss / 10), CH_ZERO + 8'(ss % 10)};
                // Corrupt one position of an otherwise good line.
                if (kind >= 70) chars[$urandom_range(0, 5)] = text_byte();
            end else if (kind < 86 || (kind >= 92 && kind < 94)) begin
                n = (kind < 86) ? $urandom_range(0, 12) : $urandom_range(58, 70);
                repeat (n)
                    chars.push_back($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                         : text_byte());
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 10)) chars.push_back(8'($urandom_range(0, 255)));
            end
            if (kind >= 94) begin
                repeat ($urandom_range(1, 3))
                    chars.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end else if (kind < 86 || kind >= 92) begin
                chars.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            send_chars(chars, 1'b0, typed_res);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d characters; results: ok %0d, length %0d, non-digit %0d",
                 items_sent, status_seen[ST_OK], status_seen[ST_LEN], status_seen[ST_DIGIT]);
        $display("range errors: hour %0d, minute %0d, second %0d; mismatches %0d",
                 status_seen[ST_HOUR], status_seen[ST_MIN], status_seen[ST_SEC], mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS hhmmss_line_to_seconds");
        end else begin
            $display("FAIL hhmmss_line_to_seconds");
        end
        $finish;
    end

endmodule
